[hdl/nrmc_pkg.sv]
`default_nettype none
package nrmc_pkg;

	localparam int FIELD_CHARS_DEF = 11;
	localparam int FIELD_CHARS_MAX = 11;
	localparam int TIME_CHARS = 6;
	localparam int HEMI_CHARS = 1;
	localparam int DATE_CHARS = 6;
	localparam int NUM_SLOTS = 7;
	localparam int LEN_W = 4;
	localparam int MEM_AW = $clog2(3 * FIELD_CHARS_MAX + TIME_CHARS + 2 * HEMI_CHARS + DATE_CHARS);
	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] SLOT_TIME = 3'd0;
	localparam logic [2:0] SLOT_LAT  = 3'd1;
	localparam logic [2:0] SLOT_LATH = 3'd2;
	localparam logic [2:0] SLOT_LON  = 3'd3;
	localparam logic [2:0] SLOT_LONH = 3'd4;
	localparam logic [2:0] SLOT_SPD  = 3'd5;
	localparam logic [2:0] SLOT_DATE = 3'd6;
	localparam logic [2:0] NO_SLOT   = 3'd7;
	localparam logic [2:0] CODE_NONE = 3'd7;

	localparam logic REG_INTERVAL = 1'b0;

	localparam logic [31:0] INTERVAL_RESET = 32'd5000;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_RUN   = 1'b1;

	typedef logic [NUM_SLOTS-1:0][LEN_W-1:0] len_vec_t;

	// One queue entry: either a character store or a run request with the line summary
	typedef struct packed {
		logic              kind;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        data;
		logic              fix;
		len_vec_t          lens;
	} cmd_t;

	// "$GPRMC"
	function automatic logic [7:0] prefix_char(input logic [2:0] p);
		logic [7:0] c;
		unique case (p)
			3'd0: c = 8'h24;
			3'd1: c = 8'h47;
			3'd2: c = 8'h50;
			3'd3: c = 8'h52;
			3'd4: c = 8'h4D;
			3'd5: c = 8'h43;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] slot_of_comma(input logic [3:0] n);
		logic [2:0] s;
		unique case (n)
			4'd1: s = SLOT_TIME;
			4'd3: s = SLOT_LAT;
			4'd4: s = SLOT_LATH;
			4'd5: s = SLOT_LON;
			4'd6: s = SLOT_LONH;
			4'd7: s = SLOT_SPD;
			4'd9: s = SLOT_DATE;
			default: s = NO_SLOT;
		endcase
		return s;
	endfunction

	function automatic logic [LEN_W-1:0] slot_cap(input logic [2:0] s, input int fc);
		int c;
		unique case (s) inside
			SLOT_TIME: c = TIME_CHARS;
			SLOT_LAT, SLOT_LON, SLOT_SPD: c = fc;
			SLOT_LATH, SLOT_LONH: c = HEMI_CHARS;
			SLOT_DATE: c = DATE_CHARS;
			default: c = 0;
		endcase
		return LEN_W'(c);
	endfunction

	function automatic logic [MEM_AW-1:0] slot_base(input logic [2:0] s, input int fc);
		int b;
		unique case (s)
			SLOT_TIME: b = 0;
			SLOT_LAT:  b = TIME_CHARS;
			SLOT_LATH: b = TIME_CHARS + fc;
			SLOT_LON:  b = TIME_CHARS + fc + HEMI_CHARS;
			SLOT_LONH: b = TIME_CHARS + 2 * fc + HEMI_CHARS;
			SLOT_SPD:  b = TIME_CHARS + 2 * fc + 2 * HEMI_CHARS;
			SLOT_DATE: b = TIME_CHARS + 3 * fc + 2 * HEMI_CHARS;
			default:   b = 0;
		endcase
		return MEM_AW'(b);
	endfunction

endpackage
`default_nettype wire

[hdl/nrmc_queue.sv]
`default_nettype none
module nrmc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire nrmc_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output nrmc_pkg::cmd_t     pop_cmd,
	output logic               empty
);
	import nrmc_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full    = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + (PW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");

endmodule
`default_nettype wire

[hdl/nrmc_front.sv]
`default_nettype none
module nrmc_front #(
	parameter int FIELD_CHARS = nrmc_pkg::FIELD_CHARS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          req_type,
	input  wire logic [7:0]    rx_byte,
	input  wire logic [31:0]   interval_ticks,
	input  wire logic          q_full,
	output logic               push,
	output nrmc_pkg::cmd_t     cmd
);
	import nrmc_pkg::*;

	localparam logic [1:0] FIX_IDLE  = 2'd0;
	localparam logic [1:0] FIX_COMMA = 2'd1;
	localparam logic [1:0] FIX_A     = 2'd2;

	logic        paused_q, paused_d;
	logic [31:0] tick_count_q, tick_count_d;
	logic [2:0]  line_pos_q, line_pos_d;
	logic        prefix_ok_q, prefix_ok_d;
	logic [3:0]  comma_count_q, comma_count_d;
	logic [1:0]  fix_state_q, fix_state_d;
	logic        fix_seen_q, fix_seen_d;
	logic        dot_seen_q, dot_seen_d;
	len_vec_t    lens_q, lens_d;

	logic        accept;
	logic [32:0] tick_next;
	logic [2:0]  wr_slot;
	logic [LEN_W-1:0] cur_len;
	logic        is_comma;

	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign tick_next = {1'b0, tick_count_q} + 33'd1;
	assign wr_slot   = slot_of_comma(comma_count_q);
	assign cur_len   = (wr_slot == NO_SLOT) ? '0 : lens_q[wr_slot];
	assign is_comma  = (rx_byte == CH_COMMA);

	always_comb begin
		paused_d      = paused_q;
		tick_count_d  = tick_count_q;
		line_pos_d    = line_pos_q;
		prefix_ok_d   = prefix_ok_q;
		comma_count_d = comma_count_q;
		fix_state_d   = fix_state_q;
		fix_seen_d    = fix_seen_q;
		dot_seen_d    = dot_seen_q;
		lens_d        = lens_q;
		push          = 1'b0;
		cmd.kind      = CMD_WRITE;
		cmd.addr      = slot_base(wr_slot, FIELD_CHARS) + MEM_AW'(cur_len);
		cmd.data      = rx_byte;
		cmd.fix       = fix_seen_q;
		cmd.lens      = lens_q;

		if (accept && req_type) begin
			// ticks run in every phase; expiry reopens the window
			if (tick_next >= {1'b0, interval_ticks}) begin
				tick_count_d = '0;
				paused_d     = 1'b0;
			end else begin
				tick_count_d = tick_next[31:0];
			end
		end else if (accept && !paused_q) begin
			if (rx_byte == CH_NL) begin
				if (prefix_ok_q && line_pos_q == 3'd6) begin
					push     = 1'b1;
					cmd.kind = CMD_RUN;
					paused_d = 1'b1;
				end
				line_pos_d    = '0;
				prefix_ok_d   = 1'b1;
				comma_count_d = '0;
				fix_state_d   = FIX_IDLE;
				fix_seen_d    = 1'b0;
				dot_seen_d    = 1'b0;
				lens_d        = '0;
			end else begin
				if (line_pos_q < 3'd6) begin
					if (rx_byte != prefix_char(line_pos_q))
						prefix_ok_d = 1'b0;
					line_pos_d = line_pos_q + 3'd1;
				end

				unique case (fix_state_q)
					FIX_IDLE:  fix_state_d = is_comma ? FIX_COMMA : FIX_IDLE;
					FIX_COMMA: fix_state_d = (rx_byte == CH_A) ? FIX_A :
						is_comma ? FIX_COMMA : FIX_IDLE;
					default: begin
						if (is_comma) begin
							fix_seen_d  = 1'b1;
							fix_state_d = FIX_COMMA;
						end else begin
							fix_state_d = FIX_IDLE;
						end
					end
				endcase

				if (is_comma) begin
					if (comma_count_q != 4'd15)
						comma_count_d = comma_count_q + 4'd1;
				end else if (wr_slot != NO_SLOT) begin
					// time field stops at its first dot
					if (wr_slot == SLOT_TIME && rx_byte == CH_DOT)
						dot_seen_d = 1'b1;
					if (!(wr_slot == SLOT_TIME && (dot_seen_q || rx_byte == CH_DOT)) &&
					    cur_len < slot_cap(wr_slot, FIELD_CHARS)) begin
						push            = 1'b1;
						lens_d[wr_slot] = cur_len + LEN_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q      <= 1'b0;
			tick_count_q  <= '0;
			line_pos_q    <= '0;
			prefix_ok_q   <= 1'b1;
			comma_count_q <= '0;
			fix_state_q   <= FIX_IDLE;
			fix_seen_q    <= 1'b0;
			dot_seen_q    <= 1'b0;
			lens_q        <= '0;
		end else begin
			paused_q      <= paused_d;
			tick_count_q  <= tick_count_d;
			line_pos_q    <= line_pos_d;
			prefix_ok_q   <= prefix_ok_d;
			comma_count_q <= comma_count_d;
			fix_state_q   <= fix_state_d;
			fix_seen_q    <= fix_seen_d;
			dot_seen_q    <= dot_seen_d;
			lens_q        <= lens_d;
		end
	end

	a_run_pauses: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd.kind == CMD_RUN) |=> paused_q)
		else $error("run issued without pausing");

endmodule
`default_nettype wire

[hdl/nrmc_back.sv]
`default_nettype none
module nrmc_back #(
	parameter int FIELD_CHARS = nrmc_pkg::FIELD_CHARS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire nrmc_pkg::cmd_t q_cmd,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         field_code,
	output logic [7:0]         out_char,
	output logic               sentence_valid,
	output logic               last_of_run
);
	import nrmc_pkg::*;

	localparam int MEM_DEPTH = 3 * FIELD_CHARS + TIME_CHARS + 2 * HEMI_CHARS + DATE_CHARS;
	localparam int AW = $clog2(MEM_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_SEND = 2'd2;

	// date is sent as yy mm dd from stored dd mm yy
	function automatic logic [LEN_W-1:0] date_idx(input logic [3:0] p);
		logic [LEN_W-1:0] i;
		unique case (p)
			4'd2: i = LEN_W'(4);
			4'd3: i = LEN_W'(5);
			4'd4: i = LEN_W'(2);
			4'd5: i = LEN_W'(3);
			4'd6: i = LEN_W'(0);
			4'd7: i = LEN_W'(1);
			default: i = '0;
		endcase
		return i;
	endfunction

	logic [7:0]  mem [MEM_DEPTH];
	logic [7:0]  rd_data_q;

	logic [1:0]  state_q, state_d;
	logic [2:0]  slot_q, slot_d;
	logic [3:0]  pos_q, pos_d;
	logic [5:0]  cnt_q, cnt_d;
	logic [5:0]  total_q, total_d;
	len_vec_t    lens_q, lens_d;
	logic        lit_q, lit_d;
	logic [7:0]  lit_char_q, lit_char_d;
	logic [2:0]  code_q, code_d;

	logic        out_valid_q, out_valid_d;
	logic [2:0]  code_out_q, code_out_d;
	logic [7:0]  char_out_q, char_out_d;
	logic        sv_out_q, sv_out_d;
	logic        last_out_q, last_out_d;

	logic        out_free;
	logic [5:0]  run_total;
	logic        rd_en, wr_en;
	logic [MEM_AW-1:0] rd_addr;
	logic [LEN_W-1:0]  didx;

	assign out_free = !out_valid_q || !out_stall;
	assign didx     = date_idx(pos_q);

	always_comb begin
		run_total = 6'd2;
		for (int i = 0; i < NUM_SLOTS; i++)
			run_total = run_total + 6'(q_cmd.lens[i]);
	end

	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		pos_d       = pos_q;
		cnt_d       = cnt_q;
		total_d     = total_q;
		lens_d      = lens_q;
		lit_d       = lit_q;
		lit_char_d  = lit_char_q;
		code_d      = code_q;
		out_valid_d = out_valid_q && out_stall;
		code_out_d  = code_out_q;
		char_out_d  = char_out_q;
		sv_out_d    = sv_out_q;
		last_out_d  = last_out_q;
		pop         = 1'b0;
		rd_en       = 1'b0;
		wr_en       = 1'b0;
		rd_addr     = slot_base(slot_q, FIELD_CHARS) + MEM_AW'(pos_q);

		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					if (q_cmd.kind == CMD_WRITE) begin
						pop   = 1'b1;
						wr_en = 1'b1;
					end else if (q_cmd.fix) begin
						pop     = 1'b1;
						lens_d  = q_cmd.lens;
						total_d = run_total;
						cnt_d   = '0;
						slot_d  = SLOT_TIME;
						pos_d   = '0;
						state_d = ST_READ;
					end else if (out_free) begin
						// no fix: one alert item closes the run
						pop         = 1'b1;
						out_valid_d = 1'b1;
						code_out_d  = CODE_NONE;
						char_out_d  = 8'h00;
						sv_out_d    = 1'b0;
						last_out_d  = 1'b1;
					end
				end
			end
			ST_READ: begin
				if (slot_q != SLOT_DATE) begin
					if (pos_q < lens_q[slot_q]) begin
						rd_en   = 1'b1;
						lit_d   = 1'b0;
						code_d  = slot_q;
						pos_d   = pos_q + 4'd1;
						state_d = ST_SEND;
					end else begin
						slot_d = slot_q + 3'd1;
						pos_d  = '0;
					end
				end else if (pos_q < 4'd2) begin
					lit_d      = 1'b1;
					lit_char_d = (pos_q == 4'd0) ? CH_TWO : CH_ZERO;
					code_d     = SLOT_DATE;
					pos_d      = pos_q + 4'd1;
					state_d    = ST_SEND;
				end else begin
					rd_addr = slot_base(SLOT_DATE, FIELD_CHARS) + MEM_AW'(didx);
					pos_d   = pos_q + 4'd1;
					if (didx < lens_q[SLOT_DATE]) begin
						rd_en   = 1'b1;
						lit_d   = 1'b0;
						code_d  = SLOT_DATE;
						state_d = ST_SEND;
					end
				end
			end
			default: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					code_out_d  = code_q;
					char_out_d  = lit_q ? lit_char_q : rd_data_q;
					sv_out_d    = 1'b1;
					last_out_d  = (cnt_q == total_q - 6'd1);
					cnt_d       = cnt_q + 6'd1;
					state_d     = (cnt_q == total_q - 6'd1) ? ST_IDLE : ST_READ;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[q_cmd.addr[AW-1:0]] <= q_cmd.data;
		if (rd_en)
			rd_data_q <= mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			total_q     <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			cnt_q       <= cnt_d;
			total_q     <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q     <= slot_d;
		pos_q      <= pos_d;
		lens_q     <= lens_d;
		lit_q      <= lit_d;
		lit_char_q <= lit_char_d;
		code_q     <= code_d;
		code_out_q <= code_out_d;
		char_out_q <= char_out_d;
		sv_out_q   <= sv_out_d;
		last_out_q <= last_out_d;
	end

	assign out_valid      = out_valid_q;
	assign field_code     = code_out_q;
	assign out_char       = char_out_q;
	assign sentence_valid = sv_out_q;
	assign last_of_run    = last_out_q;

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (cnt_q < total_q))
		else $error("run count past its total");
	a_alert_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && field_code == CODE_NONE) |-> (last_of_run && !sentence_valid && out_char == 8'h00))
		else $error("alert item malformed");
	a_no_pop_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pop)
		else $error("queue popped during a run");

endmodule
`default_nettype wire

[hdl/nmea_rmc_sentence_parser.sv]
// Input: one item (byte or millisecond tick) accepted per cycle while the command queue has room.
// A newline ending a $GPRMC line queues a run; without a fix the run is one alert item.
// Each result character is read from the field memory, then placed in the output register,
// and a full run gives up to 49 results.
// Asynchronous active-low reset clears all control state; the field memory is not cleared.
`default_nettype none
module nmea_rmc_sentence_parser #(
	parameter int FIELD_CHARS = nrmc_pkg::FIELD_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input item channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [7:0]  rx_byte,
	// result item channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       field_code,
	output logic [7:0]       out_char,
	output logic             sentence_valid,
	output logic             last_of_run
);
	import nrmc_pkg::*;

	logic [31:0] interval_q;
	logic        reg_idx;
	logic        q_full, q_empty, q_push, q_pop;
	cmd_t        push_cmd, pop_cmd;

	// Register file: one 32-bit register, interval_ticks, at byte address 0.
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign prdata  = (reg_idx == REG_INTERVAL) ? interval_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (psel && penable && pwrite && reg_idx == REG_INTERVAL) begin
			interval_q <= pwdata;
		end
	end

	// Front: takes items, tracks line state and the tick window, turns field
	// bytes into store commands and a matching line's newline into a run request.
	nrmc_front #(.FIELD_CHARS(FIELD_CHARS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.rx_byte       (rx_byte),
		.interval_ticks(interval_q),
		.q_full        (q_full),
		.push          (q_push),
		.cmd           (push_cmd)
	);

	// Short queue: keeps store commands queued behind a run so the run reads
	// the characters of its own line, while the front keeps taking items.
	nrmc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.pop_cmd (pop_cmd),
		.empty   (q_empty)
	);

	// Back: owns the field memory, performs stores and sequences each run
	// into the output register.
	nrmc_back #(.FIELD_CHARS(FIELD_CHARS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_cmd         (pop_cmd),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.field_code    (field_code),
		.out_char      (out_char),
		.sentence_valid(sentence_valid),
		.last_of_run   (last_of_run)
	);

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;

	import nrmc_pkg::*;

	localparam string RMC_TAG = "$GPRMC";

	typedef struct packed {
		logic [2:0] code;
		logic [7:0] ch;
		logic       valid;
		logic       last;
	} rmc_char_t;

	typedef enum logic [1:0] {FX_IDLE, FX_COMMA, FX_COMMA_A} fix_scan_t;

	// Tracks the parser state per accepted item and holds the characters still to come out.
	class rmc_scoreboard;
		bit [31:0]  window;
		bit         waiting;
		bit [31:0]  tick_cnt;
		int         tag_pos;
		bit         tag_ok;
		int         comma_num;
		fix_scan_t  fix_fsm;
		bit         fix_found;
		bit         frac_started;
		logic [7:0] fld_buf[7][FIELD_CHARS_DEF];
		int         fld_len[7];
		rmc_char_t  expected_chars[$];
		int         mismatches;
		int         live_items;

		function new();
			window = INTERVAL_RESET;
			restart_line();
		endfunction

		function void restart_line();
			tag_pos = 0;
			tag_ok = 1'b1;
			comma_num = 0;
			fix_fsm = FX_IDLE;
			fix_found = 1'b0;
			frac_started = 1'b0;
			foreach (fld_len[i])
				fld_len[i] = 0;
		endfunction

		function logic [2:0] slot_for(int n);
			case (n)
				1: return SLOT_TIME;
				3: return SLOT_LAT;
				4: return SLOT_LATH;
				5: return SLOT_LON;
				6: return SLOT_LONH;
				7: return SLOT_SPD;
				9: return SLOT_DATE;
				default: return NO_SLOT;
			endcase
		endfunction

		function int room_of(logic [2:0] s);
			case (s)
				SLOT_TIME: return TIME_CHARS;
				SLOT_LATH, SLOT_LONH: return HEMI_CHARS;
				SLOT_DATE: return DATE_CHARS;
				default: return FIELD_CHARS_DEF;
			endcase
		endfunction

		function void store_char(logic [7:0] c);
			logic [2:0] s;
			if (tag_pos < 6) begin
				if (c != RMC_TAG[tag_pos])
					tag_ok = 1'b0;
				tag_pos++;
			end
			case (fix_fsm)
				FX_IDLE: begin
					if (c == CH_COMMA)
						fix_fsm = FX_COMMA;
				end
				FX_COMMA: begin
					if (c == CH_A)
						fix_fsm = FX_COMMA_A;
					else if (c != CH_COMMA)
						fix_fsm = FX_IDLE;
				end
				default: begin
					if (c == CH_COMMA) begin
						fix_found = 1'b1;
						fix_fsm = FX_COMMA;
					end else begin
						fix_fsm = FX_IDLE;
					end
				end
			endcase
			if (c == CH_COMMA) begin
				if (comma_num < 15)
					comma_num++;
				return;
			end
			s = slot_for(comma_num);
			if (s == NO_SLOT)
				return;
			if (s == SLOT_TIME) begin
				// drop the time field from its first dot on
				if (c == CH_DOT)
					frac_started = 1'b1;
				if (frac_started)
					return;
			end
			if (fld_len[s] < room_of(s)) begin
				fld_buf[s][fld_len[s]] = c;
				fld_len[s]++;
			end
		endfunction

		function void add(logic [2:0] code, logic [7:0] ch, logic valid);
			rmc_char_t r;
			r.code = code;
			r.ch = ch;
			r.valid = valid;
			r.last = 1'b0;
			expected_chars.push_back(r);
		endfunction

		function void note_input(bit is_tick, logic [7:0] b);
			logic [32:0] next_cnt;
			if (is_tick) begin
				live_items++;
				next_cnt = {1'b0, tick_cnt} + 33'd1;
				if (next_cnt >= {1'b0, window}) begin
					tick_cnt = '0;
					waiting = 1'b0;
				end else begin
					tick_cnt = next_cnt[31:0];
				end
				return;
			end
			if (waiting)
				return;
			live_items++;
			if (b != CH_NL) begin
				store_char(b);
				return;
			end
			if (tag_ok && tag_pos == 6) begin
				if (fix_found) begin
					for (int s = 0; s < 6; s++)
						for (int i = 0; i < fld_len[s]; i++)
							add(3'(s), fld_buf[s][i], 1'b1);
					// date goes out as 20 yy mm dd
					add(SLOT_DATE, CH_TWO, 1'b1);
					add(SLOT_DATE, CH_ZERO, 1'b1);
					for (int k = 2; k >= 0; k--)
						for (int i = 2 * k; i < 2 * k + 2 && i < fld_len[SLOT_DATE]; i++)
							add(SLOT_DATE, fld_buf[SLOT_DATE][i], 1'b1);
				end else begin
					add(CODE_NONE, 8'h00, 1'b0);
				end
				expected_chars[expected_chars.size() - 1].last = 1'b1;
				waiting = 1'b1;
			end
			restart_line();
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void check_result(rmc_char_t got);
			rmc_char_t want;
			if (expected_chars.size() == 0) begin
				flag($sformatf("%0t: unexpected result code %0d char %02h valid %b last %b",
					$time, got.code, got.ch, got.valid, got.last));
				return;
			end
			want = expected_chars.pop_front();
			if (got !== want)
				flag($sformatf({"%0t: result mismatch: expected code %0d char %02h valid %b",
					" last %b, got code %0d char %02h valid %b last %b"}, $time, want.code,
					want.ch, want.valid, want.last, got.code, got.ch, got.valid, got.last));
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  field_code;
	logic [7:0]  out_char;
	logic        sentence_valid;
	logic        last_of_run;

	rmc_scoreboard sb;
	logic [8:0]    line_bytes[$];   // {is_tick, byte} per item
	int            src_idle;
	int            dst_idle;
	bit            hold_req;
	int            hold_left;
	int unsigned   cycle_count;

	nmea_rmc_sentence_parser u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: take results, stall at random, and hold off for a long stretch on request.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(rmc_char_t'({field_code, out_char, sentence_valid, last_of_run}));
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		out_stall <= (hold_left > 0) || ($urandom_range(99) < dst_idle);
		if (hold_left > 0)
			hold_left--;
	end

	// Runaway guard: end the run when the cycle budget is used up.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic void push_byte(logic [7:0] b);
		line_bytes.push_back({1'b0, b});
	endfunction

	function automatic void push_tick();
		// the byte lane carries junk on a tick
		line_bytes.push_back({1'b1, 8'($urandom_range(255))});
	endfunction

	function automatic void push_text(string s);
		foreach (s[i])
			push_byte(s[i]);
	endfunction

	function automatic void push_digits(int n);
		repeat (n)
			push_byte(8'h30 + 8'($urandom_range(9)));
	endfunction

	// Mostly digits, some dots and letters, and now and then any byte but newline and comma.
	function automatic void push_chars(int n);
		int pick;
		logic [7:0] c;
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				c = 8'h30 + 8'($urandom_range(9));
			end else if (pick < 62) begin
				c = CH_DOT;
			end else if (pick < 77) begin
				c = 8'h41 + 8'($urandom_range(25));
			end else begin
				do
					c = 8'($urandom_range(255));
				while (c == CH_NL || c == CH_COMMA);
			end
			push_byte(c);
		end
	endfunction

	// Keep most fields short; a few run past the field width to hit truncation.
	function automatic int rand_len();
		return ($urandom_range(99) < 85) ? $urandom_range(5) : $urandom_range(14, 6);
	endfunction

	function automatic void push_field(int f);
		string hemi;
		hemi = "NSEW";
		case (f)
			1: begin
				if ($urandom_range(99) < 70) begin
					push_digits(6);
					push_byte(CH_DOT);
					push_digits(2);
				end else begin
					push_chars(rand_len());
				end
			end
			2: begin
				if ($urandom_range(99) < 75)
					push_byte(CH_A);
				else if ($urandom_range(99) < 60)
					push_text("V");
				else
					push_chars($urandom_range(2));
			end
			3, 5, 7: push_chars(rand_len());
			4, 6: begin
				if ($urandom_range(99) < 80)
					push_byte(hemi[$urandom_range(3)]);
				else
					push_chars($urandom_range(3));
			end
			9: begin
				if ($urandom_range(99) < 80)
					push_digits(6);
				else
					push_chars($urandom_range(8));
			end
			default: push_chars($urandom_range(3));
		endcase
	endfunction

	// Build one RMC line; with corrupt set, one prefix character is replaced.
	function automatic void build_rmc(bit corrupt);
		string tag;
		int nf;
		logic [7:0] c;
		tag = RMC_TAG;
		if (corrupt) begin
			do
				c = 8'($urandom_range(255, 1));
			while (c == CH_NL);
			tag[$urandom_range(5)] = c;
		end
		push_text(tag);
		nf = ($urandom_range(99) < 80) ? 12 : $urandom_range(11);
		for (int f = 1; f <= nf; f++) begin
			push_byte(CH_COMMA);
			push_field(f);
		end
		if ($urandom_range(99) < 20)
			push_byte(CH_CR);
		push_byte(CH_NL);
	endfunction

	// Offer one item, hold it until it is taken, then note it in the scoreboard.
	task automatic drive_item(bit is_tick, logic [7:0] b);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= is_tick;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(is_tick, b);
	endtask

	task automatic drive_line();
		foreach (line_bytes[i])
			drive_item(line_bytes[i][8], line_bytes[i][7:0]);
		line_bytes.delete();
	endtask

	// Write the interval register, then read it back.
	task automatic cfg_interval(logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_INTERVAL, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.window = v;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== v)
			sb.flag($sformatf("%0t: interval readback %08h, wrote %08h", $time, prdata, v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drop valid, wait for every expected result, then let the block drain its queue.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (120)
			@(posedge clk);
	endtask

	task automatic run_random(int target);
		int first;
		int rmc_lines;
		int pick;
		first = sb.live_items;
		rmc_lines = 0;
		while (sb.live_items - first < target) begin
			pick = $urandom_range(99);
			if (sb.waiting) begin
				// paused: mostly ticks to reopen the window, some bytes that must be ignored
				if (pick < 15)
					push_byte(8'($urandom_range(255)));
				else
					push_tick();
			end else if (pick < 72) begin
				// hold the result side off during one run so the input queue backs up
				if (rmc_lines == 2)
					hold_req = 1'b1;
				rmc_lines++;
				build_rmc(1'b0);
			end else if (pick < 82) begin
				build_rmc(1'b1);
			end else if (pick < 88) begin
				// line that ends before the prefix is complete
				push_text(RMC_TAG.substr(0, $urandom_range(5) - 1));
				push_chars($urandom_range(4));
				push_byte(CH_NL);
			end else if (pick < 95) begin
				repeat ($urandom_range(8, 1)) begin
					if ($urandom_range(99) < 20)
						push_byte(CH_NL);
					else
						push_byte(8'($urandom_range(255)));
				end
			end else begin
				repeat ($urandom_range(4, 1))
					push_tick();
			end
			drive_line();
		end
	endtask

	initial begin
		sb = new();
		src_idle = 9;
		dst_idle = 54;
		hold_req = 1'b0;
		hold_left = 0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every tick reopens the window.
		cfg_interval(32'd1);
		// RMC line without a fix: one invalid result
		push_text(RMC_TAG);
		push_byte(CH_NL);
		push_tick();
		// extreme bytes in a line that fails the prefix: no result, no pause
		push_byte(8'hFF);
		push_byte(8'h00);
		push_text("GPRMC");
		push_byte(CH_NL);
		// fix with every field missing: only the date's leading 20 comes out
		push_text("$GPRMC,,A,");
		push_byte(CH_NL);
		push_tick();
		drive_line();
		settle();

		cfg_interval(32'($urandom_range(9, 2)));
		run_random(100);
		settle();

		// Widest interval: after the first run the block stays paused and drops bytes.
		src_idle = 54;
		dst_idle = 9;
		cfg_interval(32'hFFFF_FFFF);
		run_random(30);
		settle();

		cfg_interval(32'($urandom_range(9, 1)));
		run_random(90);
		settle();

		src_idle = 0;
		dst_idle = 0;
		cfg_interval(32'($urandom_range(4, 1)));
		run_random(70);
		settle();

		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
hdl/nrmc_pkg.sv
hdl/nrmc_queue.sv
hdl/nrmc_front.sv
hdl/nrmc_back.sv
hdl/nmea_rmc_sentence_parser.sv
verif/tb.sv
